// ===== hdl/uvs_pkg.sv =====
// Shared package for the UV sphere cell vertex generator.
// Types, register codes, polynomial constants and corner tables.
// No dependencies.
package uvs_pkg;

   // default parameter values
   localparam int MAX_SEGMENTS_DEF = 1024;
   localparam int ANGLE_BITS_DEF   = 16;

   // fixed field widths
   localparam int CELL_W     = 10;
   localparam int SEG_W      = 11;
   localparam int RAD_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIVR_W     = SEG_W + 1;
   localparam int MAG_W      = 15;
   localparam int PMAG_W     = 23;
   localparam int NORM_W     = 16;
   localparam int POS_W      = 24;
   localparam int TEX_W      = 16;
   localparam int MUL_W      = 31;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG   = 2'd2;

   // register reset values
   localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
   localparam logic [SEG_W-1:0] LAT_RST    = 11'd32;
   localparam logic [SEG_W-1:0] LONG_RST   = 11'd16;

   // sin(pi/2 * t) Taylor coefficients, Q30
   localparam logic [MUL_W-1:0] SC1 = 31'd1686629713;
   localparam logic [MUL_W-1:0] SC3 = 31'd693598668;
   localparam logic [MUL_W-1:0] SC5 = 31'd85569306;
   localparam logic [MUL_W-1:0] SC7 = 31'd5026995;
   localparam logic [MUL_W-1:0] SC9 = 31'd172272;

   // corners 0:(0,0) 1:(1,0) 2:(1,1) 3:(0,1), bit c holds the offset
   localparam logic [3:0] CORNER_DI = 4'b0110;
   localparam logic [3:0] CORNER_DJ = 4'b1100;

   // one classified cell as it sits in the queue
   typedef struct packed {
      logic [CELL_W-1:0] around;
      logic [CELL_W-1:0] band;
      logic              bad;
      logic [SEG_W-1:0]  lat;
      logic [SEG_W-1:0]  lon;
      logic [RAD_W-1:0]  radius;
   } cell_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // signed value as sign and magnitude
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sval_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV_START,
      BK_DIV_WAIT,
      BK_SIN,
      BK_CORN,
      BK_EMIT
   } back_state_type;

   // vertex number to corner
   function automatic logic [1:0] vtx_corner(input logic [2:0] k);
      logic [1:0] c;
      unique case (k)
         3'd0:    c = 2'd0;
         3'd1:    c = 2'd1;
         3'd2:    c = 2'd2;
         3'd3:    c = 2'd0;
         3'd4:    c = 2'd2;
         3'd5:    c = 2'd3;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // quadrant folding of sin or cos from the two quarter-wave values
   function automatic sval_type trig_sel(input logic [1:0] quad,
                                         input logic [MAG_W-1:0] st,
                                         input logic [MAG_W-1:0] ct,
                                         input logic want_cos);
      sval_type v;
      logic     swap;
      logic     neg;
      swap = want_cos ? ~quad[0] : quad[0];
      neg  = want_cos ? (quad[1] ^ quad[0]) : quad[1];
      v.mag = swap ? ct : st;
      v.neg = neg & (v.mag != '0);
      return v;
   endfunction

endpackage

// ===== hdl/uv_sphere_cell_vertex_generator_top.sv =====
// Top level of the UV sphere cell vertex generator.
// Depends on uvs_pkg, uvs_front, uvs_queue, uvs_back.
//
// Channel   | Direction | Ports                     | Beat taken when
// ----------+-----------+---------------------------+--------------------------
// request   | in        | start, busy, req_*        | start & !busy
// response  | out       | rsp_valid, rsp_*          | rsp_valid (one cycle each)
// csr write | in        | csr_valid, csr_ready, csr_* | csr_valid & csr_ready
//
// A cell in range spends most of its time in the back end on eight serial
// divisions on the one radix-2 divider, DW = max(ANGLE_BITS,15)+12 bits wide
// (28 at the defaults), then on the sine polynomial and the corner products
// on the one shared 31x31 multiplier. Its six vertices leave back to back
// while the next cell is already being worked.
// A cell out of range needs no math and goes straight to the emitter.
// Reset is synchronous; the queue holds two cells, busy is high while full.
module uv_sphere_cell_vertex_generator_top import uvs_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CELL_W-1:0]        req_cell_around,
   input  logic [CELL_W-1:0]        req_cell_band,
   output logic                     rsp_valid,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic signed [POS_W-1:0]  rsp_pos_z,
   output logic signed [NORM_W-1:0] rsp_norm_x,
   output logic signed [NORM_W-1:0] rsp_norm_y,
   output logic signed [NORM_W-1:0] rsp_norm_z,
   output logic [TEX_W-1:0]         rsp_tex_u,
   output logic [TEX_W-1:0]         rsp_tex_v,
   output logic                     rsp_last_of_cell,
   output logic                     rsp_bad_cell,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   q_status_type q_status;
   logic         push;
   cell_type     push_entry;
   logic         pop;
   cell_type     pop_entry;

   uvs_front #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cell_around (req_cell_around),
      .req_cell_band   (req_cell_band),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   uvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   uvs_back #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_last_of_cell (rsp_last_of_cell),
      .rsp_bad_cell     (rsp_bad_cell)
   );

endmodule

// ===== hdl/uvs_front.sv =====
// Front end: configuration registers, cell intake and range check.
// Depends on uvs_pkg; feeds uvs_queue.
module uvs_front import uvs_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CELL_W-1:0]     req_cell_around,
   input  logic [CELL_W-1:0]     req_cell_band,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  q_status_type          q_status,
   output logic                  push,
   output cell_type              push_entry
);

   logic [RAD_W-1:0] radius_ff, radius_in;
   logic [SEG_W-1:0] lat_ff, lat_in;
   logic [SEG_W-1:0] lon_ff, lon_in;
   logic [SEG_W-1:0] lat_eff;
   logic [SEG_W-1:0] lon_eff;

   // zero acts as one, above the maximum acts as the maximum
   function automatic logic [SEG_W-1:0] seg_eff(input logic [SEG_W-1:0] v);
      logic [SEG_W-1:0] r;
      if (v == '0) begin
         r = SEG_W'(1);
      end else if (32'(v) > MAX_SEGMENTS) begin
         r = SEG_W'(MAX_SEGMENTS);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS: radius_in = csr_data[RAD_W-1:0];
            CSR_LAT:    lat_in    = csr_data[SEG_W-1:0];
            CSR_LONG:   lon_in    = csr_data[SEG_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         lat_ff    <= LAT_RST;
         lon_ff    <= LONG_RST;
      end else begin
         radius_ff <= radius_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
      end
   end

   // intake and classification
   assign lat_eff = seg_eff(lat_ff);
   assign lon_eff = seg_eff(lon_ff);
   assign busy    = q_status.full;
   assign push    = start & ~q_status.full;

   always_comb begin
      push_entry.around = req_cell_around;
      push_entry.band   = req_cell_band;
      push_entry.bad    = ({1'b0, req_cell_around} >= lat_eff) |
                          ({1'b0, req_cell_band} >= lon_eff);
      push_entry.lat    = lat_eff;
      push_entry.lon    = lon_eff;
      push_entry.radius = radius_ff;
   end

endmodule

// ===== hdl/uvs_queue.sv =====
// Two-entry queue of classified cells between front and back end.
// Depends on uvs_pkg.
module uvs_queue import uvs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cell_type     push_entry,
   input  logic         pop,
   output cell_type     pop_entry,
   output q_status_type status
);

   cell_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);
   assign pop_entry    = mem_ff[rd_ff];

   // pointers and fill count
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/uvs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on uvs_pkg; used by uvs_back.
module uvs_div import uvs_pkg::*; #(
   parameter int DW = 27
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic              done,
   output logic [DW-1:0]     quotient
);

   localparam int CW = $clog2(DW + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     dq_ff, dq_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [DIVR_W:0]   rem_sh;
   logic [DIVR_W:0]   diff;
   logic              ge;

   assign done     = done_ff;
   assign quotient = dq_ff;

   // one shift and trial subtract per cycle
   always_comb begin
      rem_sh  = {rem_ff, dq_ff[DW-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(DW);
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         dq_in  = {dq_ff[DW-2:0], ge};
         rem_in = ge ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ===== hdl/uvs_back.sv =====
// Back end: sequencer over a shared divider and multiplier that works out
// angles, texture coordinates, sines, normals and positions of one cell, plus the vertex emitter.
// Depends on uvs_pkg and uvs_div.
module uvs_back import uvs_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  q_status_type              q_status,
   input  cell_type                  pop_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic signed [POS_W-1:0]   rsp_pos_z,
   output logic signed [NORM_W-1:0]  rsp_norm_x,
   output logic signed [NORM_W-1:0]  rsp_norm_y,
   output logic signed [NORM_W-1:0]  rsp_norm_z,
   output logic [TEX_W-1:0]          rsp_tex_u,
   output logic [TEX_W-1:0]          rsp_tex_v,
   output logic                      rsp_last_of_cell,
   output logic                      rsp_bad_cell
);

   localparam int AB = ANGLE_BITS;
   localparam int DW = ((AB > 15) ? AB : 15) + 12;
   localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

   // sequencer
   back_state_type    state_ff, state_in;
   cell_type          cur_ff, cur_in;
   logic [2:0]        job_ff, job_in;
   logic [2:0]        sj_ff, sj_in;
   logic [2:0]        step_ff, step_in;
   logic [1:0]        corn_ff, corn_in;
   logic [2:0]        op_ff, op_in;

   // per-cell results
   logic [AB-1:0]     ang_phi_ff [2], ang_phi_in [2];
   logic [AB-1:0]     ang_th_ff [2], ang_th_in [2];
   logic [TEX_W-1:0]  tu_ff [2], tu_in [2];
   logic [TEX_W-1:0]  tv_ff [2], tv_in [2];
   logic [MAG_W-1:0]  st_phi_ff [2], st_phi_in [2];
   logic [MAG_W-1:0]  ct_phi_ff [2], ct_phi_in [2];
   logic [MAG_W-1:0]  st_th_ff [2], st_th_in [2];
   logic [MAG_W-1:0]  ct_th_ff [2], ct_th_in [2];
   logic [MUL_W-1:0]  x_ff, x_in;
   logic [MUL_W-1:0]  x2_ff, x2_in;
   logic [MUL_W-1:0]  p_ff, p_in;
   logic [MAG_W-1:0]  nmag_ff [4][3], nmag_in [4][3];
   logic              nneg_ff [4][3], nneg_in [4][3];
   logic [PMAG_W-1:0] pmag_ff [4][3], pmag_in [4][3];

   // emitter
   logic              em_active_ff, em_active_in;
   logic [2:0]        em_k_ff, em_k_in;
   logic              em_bad_ff, em_bad_in;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  pos_ff [3], pos_in [3];
   logic [NORM_W-1:0] norm_ff [3], norm_in [3];
   logic [TEX_W-1:0]  tex_u_ff, tex_u_in;
   logic [TEX_W-1:0]  tex_v_ff, tex_v_in;
   logic              last_ff, last_in;
   logic              bad_ff, bad_in;

   // datapath temporaries
   logic              div_start;
   logic              div_done;
   logic [DW-1:0]     div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [DW-1:0]     div_q;
   logic [SEG_W-1:0]  i_idx;
   logic [SEG_W-1:0]  j_idx;
   logic [MUL_W-1:0]  mul_a;
   logic [MUL_W-1:0]  mul_b;
   logic [2*MUL_W-1:0] prod;
   logic [AB-1:0]     sin_ang;
   logic [MUL_W-1:0]  t_q30;
   logic [MUL_W-1:0]  x_sel;
   logic [MUL_W-1:0]  sub_c;
   logic [31:0]       s32;
   logic [16:0]       s_rnd;
   logic [MAG_W-1:0]  s_sat;
   logic [MAG_W-1:0]  mq_r;
   logic [PMAG_W-1:0] ps_r;
   logic              cdi;
   logic              cdj;
   sval_type          sphi;
   sval_type          cphi;
   sval_type          sth;
   sval_type          cth;
   logic [1:0]        ec;
   logic              edi;
   logic              edj;

   uvs_div #(
      .DW(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // divider operands for the current job
   always_comb begin
      i_idx = {1'b0, cur_ff.around} + SEG_W'(job_ff[0]);
      j_idx = {1'b0, cur_ff.band} + SEG_W'(job_ff[0]);
      case (job_ff[2:1])
         2'd0: begin
            div_dividend = (DW'(i_idx) << AB) + DW'(cur_ff.lat >> 1);
            div_divisor  = {1'b0, cur_ff.lat};
         end
         2'd1: begin
            div_dividend = (DW'(j_idx) << AB) + DW'(cur_ff.lon);
            div_divisor  = {cur_ff.lon, 1'b0};
         end
         2'd2: begin
            div_dividend = (DW'(i_idx) << 15) + DW'(cur_ff.lat >> 1);
            div_divisor  = {1'b0, cur_ff.lat};
         end
         default: begin
            div_dividend = (DW'(j_idx) << 15) + DW'(cur_ff.lon >> 1);
            div_divisor  = {1'b0, cur_ff.lon};
         end
      endcase
   end

   // quarter-wave argument and corner trig values
   always_comb begin
      sin_ang = sj_ff[2] ? ang_th_ff[sj_ff[1]] : ang_phi_ff[sj_ff[1]];
      t_q30   = MUL_W'(sin_ang[AB-3:0]) << (32 - AB);
      x_sel   = sj_ff[0] ? ((MUL_W'(1) << 30) - t_q30) : t_q30;
      cdi     = CORNER_DI[corn_ff];
      cdj     = CORNER_DJ[corn_ff];
      sphi    = trig_sel(ang_phi_ff[cdi][AB-1:AB-2], st_phi_ff[cdi], ct_phi_ff[cdi], 1'b0);
      cphi    = trig_sel(ang_phi_ff[cdi][AB-1:AB-2], st_phi_ff[cdi], ct_phi_ff[cdi], 1'b1);
      sth     = trig_sel(ang_th_ff[cdj][AB-1:AB-2], st_th_ff[cdj], ct_th_ff[cdj], 1'b0);
      cth     = trig_sel(ang_th_ff[cdj][AB-1:AB-2], st_th_ff[cdj], ct_th_ff[cdj], 1'b1);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = x_sel;
      mul_b = x_sel;
      sub_c = SC7;
      if (state_ff == BK_SIN) begin
         case (step_ff)
            3'd0: begin
               mul_a = x_sel;
               mul_b = x_sel;
            end
            3'd1: begin
               mul_a = SC9;
               mul_b = x2_ff;
            end
            3'd5: begin
               mul_a = p_ff;
               mul_b = x_ff;
            end
            default: begin
               mul_a = p_ff;
               mul_b = x2_ff;
            end
         endcase
         case (step_ff)
            3'd2:    sub_c = SC5;
            3'd3:    sub_c = SC3;
            3'd4:    sub_c = SC1;
            default: sub_c = SC7;
         endcase
      end else begin
         case (op_ff)
            3'd0: begin
               mul_a = MUL_W'(sphi.mag);
               mul_b = MUL_W'(cth.mag);
            end
            3'd1: begin
               mul_a = MUL_W'(cphi.mag);
               mul_b = MUL_W'(cth.mag);
            end
            3'd2: begin
               mul_a = MUL_W'(cur_ff.radius);
               mul_b = MUL_W'(nmag_ff[corn_ff][0]);
            end
            3'd3: begin
               mul_a = MUL_W'(cur_ff.radius);
               mul_b = MUL_W'(sth.mag);
            end
            default: begin
               mul_a = MUL_W'(cur_ff.radius);
               mul_b = MUL_W'(nmag_ff[corn_ff][2]);
            end
         endcase
      end
      prod  = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
      s32   = 32'(prod >> 30);
      s_rnd = 17'((33'(s32) + 33'd16384) >> 15);
      s_sat = (s_rnd > 17'd32767) ? 15'h7FFF : s_rnd[MAG_W-1:0];
      mq_r  = MAG_W'((prod + 62'd16384) >> 15);
      ps_r  = PMAG_W'((prod + 62'd128) >> 8);
   end

   // sequencer next state and datapath updates
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      job_in    = job_ff;
      sj_in     = sj_ff;
      step_in   = step_ff;
      corn_in   = corn_ff;
      op_in     = op_ff;
      ang_phi_in = ang_phi_ff;
      ang_th_in  = ang_th_ff;
      tu_in      = tu_ff;
      tv_in      = tv_ff;
      st_phi_in  = st_phi_ff;
      ct_phi_in  = ct_phi_ff;
      st_th_in   = st_th_ff;
      ct_th_in   = ct_th_ff;
      x_in       = x_ff;
      x2_in      = x2_ff;
      p_in       = p_ff;
      nmag_in    = nmag_ff;
      nneg_in    = nneg_ff;
      pmag_in    = pmag_ff;
      pop        = 1'b0;
      div_start  = 1'b0;
      em_bad_in  = em_bad_ff;

      // emitter walks six vertices
      em_active_in = em_active_ff;
      em_k_in      = em_k_ff;
      if (em_active_ff) begin
         em_k_in = em_k_ff + 3'd1;
         if (em_k_ff == 3'd5) begin
            em_active_in = 1'b0;
         end
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cur_in = pop_entry;
               job_in = 3'd0;
               state_in = pop_entry.bad ? BK_EMIT : BK_DIV_START;
            end
         end
         BK_DIV_START: begin
            div_start = 1'b1;
            state_in  = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (div_done) begin
               case (job_ff[2:1])
                  2'd0:    ang_phi_in[job_ff[0]] = div_q[AB-1:0];
                  2'd1:    ang_th_in[job_ff[0]] = div_q[AB-1:0] - QUARTER;
                  2'd2:    tu_in[job_ff[0]] = div_q[TEX_W-1:0];
                  default: tv_in[job_ff[0]] = 16'h8000 - div_q[TEX_W-1:0];
               endcase
               job_in = job_ff + 3'd1;
               if (job_ff == 3'd7) begin
                  sj_in    = 3'd0;
                  step_in  = 3'd0;
                  state_in = BK_SIN;
               end else begin
                  state_in = BK_DIV_START;
               end
            end
         end
         BK_SIN: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  x_in  = x_sel;
                  x2_in = MUL_W'((prod + 62'd536870912) >> 30);
               end
               3'd5: begin
                  step_in = 3'd0;
                  sj_in   = sj_ff + 3'd1;
                  case ({sj_ff[2], sj_ff[0]})
                     2'b00:   st_phi_in[sj_ff[1]] = s_sat;
                     2'b01:   ct_phi_in[sj_ff[1]] = s_sat;
                     2'b10:   st_th_in[sj_ff[1]] = s_sat;
                     default: ct_th_in[sj_ff[1]] = s_sat;
                  endcase
                  if (sj_ff == 3'd7) begin
                     corn_in  = 2'd0;
                     op_in    = 3'd0;
                     state_in = BK_CORN;
                  end
               end
               default: begin
                  p_in = MUL_W'(32'(sub_c) - s32);
               end
            endcase
         end
         BK_CORN: begin
            op_in = op_ff + 3'd1;
            case (op_ff)
               3'd0: begin
                  nmag_in[corn_ff][0] = mq_r;
                  nneg_in[corn_ff][0] = (sphi.neg ^ cth.neg) & (mq_r != '0);
               end
               3'd1: begin
                  nmag_in[corn_ff][2] = mq_r;
                  nneg_in[corn_ff][2] = (cphi.neg ^ cth.neg) & (mq_r != '0);
               end
               3'd2: begin
                  pmag_in[corn_ff][0] = ps_r;
               end
               3'd3: begin
                  nmag_in[corn_ff][1] = sth.mag;
                  nneg_in[corn_ff][1] = sth.neg;
                  pmag_in[corn_ff][1] = ps_r;
               end
               default: begin
                  pmag_in[corn_ff][2] = ps_r;
                  op_in   = 3'd0;
                  corn_in = corn_ff + 2'd1;
                  if (corn_ff == 2'd3) begin
                     state_in = BK_EMIT;
                  end
               end
            endcase
         end
         BK_EMIT: begin
            if (!em_active_ff) begin
               em_active_in = 1'b1;
               em_k_in      = 3'd0;
               em_bad_in    = cur_ff.bad;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // vertex fields for the emitted corner
   always_comb begin
      ec           = vtx_corner(em_k_ff);
      edi          = CORNER_DI[ec];
      edj          = CORNER_DJ[ec];
      rsp_valid_in = em_active_ff;
      last_in      = em_active_ff & (em_k_ff == 3'd5);
      bad_in       = em_active_ff & em_bad_ff;
      tex_u_in     = em_bad_ff ? '0 : tu_ff[edi];
      tex_v_in     = em_bad_ff ? '0 : tv_ff[edj];
      for (int c = 0; c < 3; c++) begin
         if (em_bad_ff) begin
            pos_in[c]  = '0;
            norm_in[c] = '0;
         end else if (nneg_ff[ec][c]) begin
            pos_in[c]  = -POS_W'(pmag_ff[ec][c]);
            norm_in[c] = -NORM_W'(nmag_ff[ec][c]);
         end else begin
            pos_in[c]  = POS_W'(pmag_ff[ec][c]);
            norm_in[c] = NORM_W'(nmag_ff[ec][c]);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         job_ff       <= 3'd0;
         sj_ff        <= 3'd0;
         step_ff      <= 3'd0;
         corn_ff      <= 2'd0;
         op_ff        <= 3'd0;
         em_active_ff <= 1'b0;
         em_k_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         sj_ff        <= sj_in;
         step_ff      <= step_in;
         corn_ff      <= corn_in;
         op_ff        <= op_in;
         em_active_ff <= em_active_in;
         em_k_ff      <= em_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      ang_phi_ff <= ang_phi_in;
      ang_th_ff  <= ang_th_in;
      tu_ff      <= tu_in;
      tv_ff      <= tv_in;
      st_phi_ff  <= st_phi_in;
      ct_phi_ff  <= ct_phi_in;
      st_th_ff   <= st_th_in;
      ct_th_ff   <= ct_th_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      p_ff       <= p_in;
      nmag_ff    <= nmag_in;
      nneg_ff    <= nneg_in;
      pmag_ff    <= pmag_in;
      em_bad_ff  <= em_bad_in;
      pos_ff     <= pos_in;
      norm_ff    <= norm_in;
      tex_u_ff   <= tex_u_in;
      tex_v_ff   <= tex_v_in;
      last_ff    <= last_in;
      bad_ff     <= bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_ff[0];
   assign rsp_pos_y        = pos_ff[1];
   assign rsp_pos_z        = pos_ff[2];
   assign rsp_norm_x       = norm_ff[0];
   assign rsp_norm_y       = norm_ff[1];
   assign rsp_norm_z       = norm_ff[2];
   assign rsp_tex_u        = tex_u_ff;
   assign rsp_tex_v        = tex_v_ff;
   assign rsp_last_of_cell = last_ff;
   assign rsp_bad_cell     = bad_ff;

endmodule

// ===== hdl/uvs_checker.sv =====
// Port-level checks for the vertex generator, bound to the top level.
// Depends on uvs_pkg and uv_sphere_cell_vertex_generator_top.
module uvs_checker import uvs_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic signed [POS_W-1:0]  rsp_pos_x,
   input logic signed [POS_W-1:0]  rsp_pos_y,
   input logic signed [POS_W-1:0]  rsp_pos_z,
   input logic signed [NORM_W-1:0] rsp_norm_x,
   input logic signed [NORM_W-1:0] rsp_norm_y,
   input logic signed [NORM_W-1:0] rsp_norm_z,
   input logic [TEX_W-1:0]         rsp_tex_u,
   input logic [TEX_W-1:0]         rsp_tex_v,
   input logic                     rsp_last_of_cell,
   input logic                     rsp_bad_cell
);

   // a cell's six beats come out back to back
   a_six_beats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_cell |-> $past(rsp_valid, 5))
      else $error("last vertex without five vertices before it");

   // out-of-range cells carry only zeros
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_cell |->
         rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0 &&
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0 &&
         rsp_tex_u == '0 && rsp_tex_v == '0)
      else $error("bad cell with nonzero fields");

   // normals stay within plus or minus one
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x != 16'sh8000 && rsp_norm_y != 16'sh8000 &&
                    rsp_norm_z != 16'sh8000)
      else $error("normal component out of range");

   // texture coordinates never exceed one
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u <= 16'd32768 && rsp_tex_v <= 16'd32768)
      else $error("texture coordinate above one");

endmodule

bind uv_sphere_cell_vertex_generator_top uvs_checker u_uvs_checker (.*);
